// ===== hw/rtl/tcgr_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console glyph renderer package
// Shared types, codes and constants for the console renderer modules.
// ----------------------------------------------------------------------------
package tcgr_pkg;

  localparam int GLYPH_WIDTH   = 8;
  localparam int GLYPH_HEIGHT  = 12;
  localparam int MAX_COLUMNS   = 256;
  localparam int MAX_ROWS      = 256;
  localparam int TAB_STOP      = 8;

  localparam int CURSOR_W      = 9;
  localparam int CURSOR_MAX    = 511;
  localparam int REG_W         = 9;
  localparam int COLUMNS_RESET = 80;
  localparam int ROWS_RESET    = 40;
  localparam int FONT_ADDR_W   = 12;

  // Configuration register indexes.
  typedef enum logic {
    REG_COLUMNS = 1'b0,
    REG_ROWS    = 1'b1
  } reg_idx_t;

  // Input opcodes.
  localparam logic OP_CHAR      = 1'b0;
  localparam logic OP_FONT_LOAD = 1'b1;

  // Result kinds.
  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_SCROLL = 1'b1;

  // Console control bytes.
  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_BS    = 8'h08;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_SPACE = 8'h20;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  char_code;
    logic [11:0] font_addr;
    logic [7:0]  font_byte;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [10:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  pattern;
    logic        last;
  } out_t;

  // Screen size after clamping, each in 1..256.
  typedef struct packed {
    logic [REG_W-1:0] cols;
    logic [REG_W-1:0] nrows;
  } screen_t;

  // Font store access: one write port and one read port.
  typedef struct packed {
    logic                   we;
    logic [FONT_ADDR_W-1:0] waddr;
    logic [7:0]             wdata;
    logic                   re;
    logic [FONT_ADDR_W-1:0] raddr;
  } font_req_t;

endpackage

// ===== hw/rtl/tcgr_font_ram.sv =====
// ----------------------------------------------------------------------------
// Glyph font store
// Single-port-write, single-port-read memory of glyph row bytes. The read
// data register holds its value on cycles without a read.
// ----------------------------------------------------------------------------
module tcgr_font_ram #(
  parameter int GLYPH_HEIGHT = tcgr_pkg::GLYPH_HEIGHT
) (
  input  logic                clk,
  input  tcgr_pkg::font_req_t req,
  output logic [7:0]          rdata
);

  localparam int DEPTH  = 256 * GLYPH_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[ADDR_W-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr[ADDR_W-1:0]];
    end
  end

endmodule

// ===== hw/rtl/tcgr_seq.sv =====
// ----------------------------------------------------------------------------
// Console sequencer
// Interprets console bytes, keeps the cursor, and steps through the glyph
// rows of one character, one font read per cycle unless the output stalls, into the output register.
// ----------------------------------------------------------------------------
module tcgr_seq #(
  parameter int GLYPH_HEIGHT = tcgr_pkg::GLYPH_HEIGHT
) (
  input  logic                clk,
  input  logic                rst,
  input  tcgr_pkg::screen_t   scr,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcgr_pkg::in_t       in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tcgr_pkg::out_t      out_data,
  output tcgr_pkg::font_req_t font_req,
  input  logic [7:0]          font_rdata
);

  localparam int DEPTH = 256 * GLYPH_HEIGHT;
  localparam int ROW_W = $clog2(GLYPH_HEIGHT);
  localparam int CW    = tcgr_pkg::CURSOR_W;
  localparam int AW    = tcgr_pkg::FONT_ADDR_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCROLL,
    S_DRAW
  } state_t;

  state_t         state;
  logic [CW-1:0]  cursor_col;
  logic [CW-1:0]  cursor_row;
  logic [7:0]     draw_col;
  logic [AW-1:0]  glyph_base;
  logic [11:0]    row_base;
  logic [ROW_W-1:0] row_cnt;
  logic           pend;
  logic [11:0]    pend_y;
  logic           pend_last;

  logic           in_fire;
  logic           load_out;
  logic           rd_go;
  logic           scroll_go;
  logic           row_done;

  logic [CW-1:0]  bs_col;
  logic           bs_draw;
  logic [CW:0]    tab_sum;
  logic [CW:0]    tab_stop_col;
  logic [CW-1:0]  tab_col;
  logic [CW-1:0]  inc_row;
  logic           wrap;
  logic [CW-1:0]  p_col;
  logic [CW-1:0]  p_row;
  logic           scroll;
  logic [CW-1:0]  d_row;

  assign in_ready  = (state == S_IDLE) && !pend;
  assign in_fire   = in_valid && in_ready;
  assign load_out  = pend && (!out_valid || out_ready);
  assign rd_go     = (state == S_DRAW) && (!pend || load_out);
  assign scroll_go = (state == S_SCROLL) && (!out_valid || out_ready);
  assign row_done  = (row_cnt == ROW_W'(GLYPH_HEIGHT - 1));

  // Cursor arithmetic for each kind of console byte.
  always_comb begin
    bs_col       = (cursor_col != '0) ? cursor_col - CW'(1) : cursor_col;
    bs_draw      = (bs_col < scr.cols) && (cursor_row < scr.nrows);
    tab_sum      = {1'b0, cursor_col} + (CW+1)'(tcgr_pkg::TAB_STOP);
    tab_stop_col = (CW+1)'((tab_sum / tcgr_pkg::TAB_STOP) * tcgr_pkg::TAB_STOP);
    tab_col      = (tab_stop_col > (CW+1)'(tcgr_pkg::CURSOR_MAX)) ?
                   CW'(tcgr_pkg::CURSOR_MAX) : tab_stop_col[CW-1:0];
    inc_row      = (cursor_row == CW'(tcgr_pkg::CURSOR_MAX)) ?
                   cursor_row : cursor_row + CW'(1);
    wrap         = (cursor_col >= scr.cols);
    p_col        = wrap ? '0 : cursor_col;
    p_row        = wrap ? inc_row : cursor_row;
    scroll       = (p_row >= scr.nrows);
    d_row        = scroll ? scr.nrows - CW'(1) : p_row;
  end

  always_comb begin
    font_req.we    = in_fire && (in_data.opcode == tcgr_pkg::OP_FONT_LOAD) &&
                     ({1'b0, in_data.font_addr} < (AW+1)'(DEPTH));
    font_req.waddr = in_data.font_addr;
    font_req.wdata = in_data.font_byte;
    font_req.re    = rd_go;
    font_req.raddr = glyph_base + AW'(row_cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cursor_col <= '0;
      cursor_row <= '0;
      row_cnt    <= '0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // Command decode on an accepted console byte.
      if (in_fire && (in_data.opcode == tcgr_pkg::OP_CHAR)) begin
        row_cnt <= '0;
        case (in_data.char_code)
          tcgr_pkg::CHR_NUL: begin
          end
          tcgr_pkg::CHR_BS: begin
            cursor_col <= bs_col;
            draw_col   <= bs_col[7:0];
            row_base   <= 12'(cursor_row[7:0] * GLYPH_HEIGHT);
            glyph_base <= AW'(tcgr_pkg::CHR_SPACE * GLYPH_HEIGHT);
            if (bs_draw) begin
              state <= S_DRAW;
            end
          end
          tcgr_pkg::CHR_LF: begin
            cursor_col <= '0;
            cursor_row <= inc_row;
          end
          tcgr_pkg::CHR_TAB: begin
            cursor_col <= tab_col;
          end
          default: begin
            // The wrapped column is below 256, so the advance cannot saturate.
            cursor_col <= p_col + CW'(1);
            cursor_row <= d_row;
            draw_col   <= p_col[7:0];
            row_base   <= 12'(d_row[7:0] * GLYPH_HEIGHT);
            glyph_base <= AW'(in_data.char_code * GLYPH_HEIGHT);
            state      <= scroll ? S_SCROLL : S_DRAW;
          end
        endcase
      end

      if (scroll_go) begin
        state <= S_DRAW;
      end

      // One font read per cycle while the read data register can take it.
      if (rd_go) begin
        pend      <= 1'b1;
        pend_y    <= row_base + 12'(row_cnt);
        pend_last <= row_done;
        row_cnt   <= row_cnt + ROW_W'(1);
        if (row_done) begin
          state <= S_IDLE;
        end
      end else if (load_out) begin
        pend <= 1'b0;
      end

      // Output register.
      if (load_out) begin
        out_valid        <= 1'b1;
        out_data.kind    <= tcgr_pkg::KIND_DRAW;
        out_data.pixel_x <= {draw_col, 3'b000};
        out_data.pixel_y <= pend_y;
        out_data.pattern <= font_rdata;
        out_data.last    <= pend_last;
      end else if (scroll_go) begin
        out_valid        <= 1'b1;
        out_data.kind    <= tcgr_pkg::KIND_SCROLL;
        out_data.pixel_x <= '0;
        out_data.pixel_y <= '0;
        out_data.pattern <= '0;
        out_data.last    <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/text_console_glyph_renderer_top.sv =====
// ----------------------------------------------------------------------------
// Text console glyph renderer
// Console byte interpreter with cursor tracking and a glyph font store.
// ----------------------------------------------------------------------------
// Each input transaction is either a console byte or a write of one byte of
// the font store. Font loads, NUL, newline, tab and a backspace whose cell is
// off screen emit nothing. A printable byte (and a backspace whose cell is on
// screen) emits an optional scroll transaction followed by one draw
// transaction per glyph row, the last one flagged. The font store has a
// single read port, so the glyph rows come out at one per cycle while the
// output side does not stall. The input is not ready while a character is
// being drawn. Font entries that were never loaded read back as unknown
// data. Configuration writes should be made only while the block is idle.
module text_console_glyph_renderer_top #(
  parameter int GLYPH_HEIGHT = tcgr_pkg::GLYPH_HEIGHT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  tcgr_pkg::in_t            in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output tcgr_pkg::out_t           out_data,
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_index,
  input  logic [tcgr_pkg::REG_W-1:0] cfg_data
);

  localparam int RW = tcgr_pkg::REG_W;

  // Raw register values as written.
  logic [RW-1:0]       columns;
  logic [RW-1:0]       rows;
  tcgr_pkg::screen_t   scr;
  tcgr_pkg::font_req_t font_req;
  logic [7:0]          font_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= RW'(tcgr_pkg::COLUMNS_RESET);
      rows    <= RW'(tcgr_pkg::ROWS_RESET);
    end else if (cfg_we) begin
      if (cfg_index == tcgr_pkg::REG_COLUMNS) begin
        columns <= cfg_data;
      end else begin
        rows <= cfg_data;
      end
    end
  end

  // The registers are clamped into the supported screen size where used.
  always_comb begin
    if (columns == '0) begin
      scr.cols = RW'(1);
    end else if (columns > RW'(tcgr_pkg::MAX_COLUMNS)) begin
      scr.cols = RW'(tcgr_pkg::MAX_COLUMNS);
    end else begin
      scr.cols = columns;
    end
    if (rows == '0) begin
      scr.nrows = RW'(1);
    end else if (rows > RW'(tcgr_pkg::MAX_ROWS)) begin
      scr.nrows = RW'(tcgr_pkg::MAX_ROWS);
    end else begin
      scr.nrows = rows;
    end
  end

  tcgr_seq #(
    .GLYPH_HEIGHT (GLYPH_HEIGHT)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .scr        (scr),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .font_req   (font_req),
    .font_rdata (font_rdata)
  );

  tcgr_font_ram #(
    .GLYPH_HEIGHT (GLYPH_HEIGHT)
  ) u_font_ram (
    .clk   (clk),
    .req   (font_req),
    .rdata (font_rdata)
  );

endmodule

// ===== verif/tb_text_console_glyph_renderer_top.sv =====
// ----------------------------------------------------------------------------
// Text console glyph renderer testbench
// Drives console bytes and font loads through the valid/ready input channel,
// rebuilds every draw and scroll transaction in a cycle-free predictor and
// checks the output channel in order, under random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_text_console_glyph_renderer_top;
  import tcgr_pkg::*;

  // Depth of the font store: one byte per glyph row for all 256 codes.
  localparam int FONT_DEPTH = 256 * GLYPH_HEIGHT;
  // A plan row with this count leaves the expectation to the predictor.
  localparam int PREDICTED = -1;
  // Cycles allowed for the queue of expected results to empty at a pause.
  localparam int DRAIN_BOUND = 20000;
  // Length of the single long receiver hold-off, and when it starts.
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER = 150;

  // A scroll transaction carries no position or pattern and is never last.
  localparam out_t SCROLL_BEAT = '{kind: KIND_SCROLL, pixel_x: '0, pixel_y: '0,
                                   pattern: '0, last: 1'b0};

  // One row of the directed plan: either a screen size change, or a single
  // input transaction with an optional hand-written result count and head.
  typedef struct {
    bit               screen;
    logic [REG_W-1:0] cols;
    logic [REG_W-1:0] nrows;
    in_t              item;
    int               count;
    out_t             head;
  } plan_step_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [REG_W-1:0] cfg_data;

  text_console_glyph_renderer_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Predictor state: the screen size as written, the cursor, and a shadow of
  // the font store with a flag per entry so no unwritten entry is ever drawn.
  logic [REG_W-1:0]    scr_cols;
  logic [REG_W-1:0]    scr_rows;
  logic [CURSOR_W-1:0] cur_col;
  logic [CURSOR_W-1:0] cur_row;
  logic [7:0]          font_img [FONT_DEPTH];
  bit                  glyph_ok [FONT_DEPTH];
  bit                  pooled [256];
  logic [7:0]          glyph_pool [$];

  // Results of the transaction just accepted, and the in-order list of all
  // results still owed by the block.
  out_t item_rows [$];
  out_t due_rows [$];
  out_t oldest;

  plan_step_t plan_steps [$];

  bit src_steady;
  int errors;
  int items_sent;
  int loads_sent;
  int screens_set;
  int outputs_seen;
  int scrolls_seen;

  function automatic string show(out_t b);
    return $sformatf("kind=%0d x=%0d y=%0d pattern=%02h last=%0d",
                     b.kind, b.pixel_x, b.pixel_y, b.pattern, b.last);
  endfunction

  // Every failure is printed and counted.
  function automatic void tally_error(string what);
    errors++;
    $display("%0t: %s", $time, what);
  endfunction

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned clamp_size(logic [REG_W-1:0] v, int unsigned hi);
    if (v < 1) begin
      return 1;
    end
    return (v > hi) ? hi : v;
  endfunction

  function automatic int unsigned sat_cursor(int unsigned v);
    return (v > CURSOR_MAX) ? CURSOR_MAX : v;
  endfunction

  // A console byte; the font fields are don't-care and get random values.
  function automatic in_t console_byte(logic [7:0] code);
    in_t it;
    it.opcode    = OP_CHAR;
    it.char_code = code;
    it.font_addr = 12'($urandom);
    it.font_byte = 8'($urandom);
    return it;
  endfunction

  function automatic in_t font_load(logic [11:0] addr, logic [7:0] bits);
    in_t it;
    it.opcode    = OP_FONT_LOAD;
    it.char_code = 8'($urandom);
    it.font_addr = addr;
    it.font_byte = bits;
    return it;
  endfunction

  // Printable codes come from the glyphs already in the store, so that
  // characters cost no font loads; a random code is used only before any
  // glyph has been loaded.
  function automatic logic [7:0] pick_printable();
    logic [7:0] c;
    do begin
      if (glyph_pool.size() != 0) begin
        c = glyph_pool[$urandom_range(0, glyph_pool.size() - 1)];
      end else begin
        c = 8'($urandom);
      end
    end while (c == CHR_NUL || c == CHR_BS || c == CHR_TAB || c == CHR_LF);
    return c;
  endfunction

  // Twelve draw transactions for one character cell, top row first.
  function automatic void draw_cell(logic [7:0] code, int unsigned col, int unsigned row);
    out_t beat;
    for (int y = 0; y < GLYPH_HEIGHT; y++) begin
      beat.kind    = KIND_DRAW;
      beat.pixel_x = 11'(col * GLYPH_WIDTH);
      beat.pixel_y = 12'(row * GLYPH_HEIGHT + y);
      beat.pattern = font_img[code * GLYPH_HEIGHT + y];
      beat.last    = (y == GLYPH_HEIGHT - 1);
      item_rows.push_back(beat);
    end
  endfunction

  // Works out what one accepted transaction does to the cursor and the font
  // shadow, and leaves the results it causes in item_rows.
  function automatic void interpret_console_item(in_t it);
    int unsigned col;
    int unsigned row;
    int unsigned cols_lim;
    int unsigned rows_lim;
    item_rows.delete();
    if (it.opcode == OP_FONT_LOAD) begin
      // Loads beyond the last glyph fall off the end of the store.
      if (it.font_addr < FONT_DEPTH) begin
        font_img[it.font_addr] = it.font_byte;
        glyph_ok[it.font_addr] = 1'b1;
      end
    end else begin
      col = cur_col;
      row = cur_row;
      cols_lim = clamp_size(scr_cols, MAX_COLUMNS);
      rows_lim = clamp_size(scr_rows, MAX_ROWS);
      case (it.char_code)
        CHR_NUL: ;
        CHR_BS: begin
          // Blank the cell to the left; a cell off screen is left alone.
          if (col > 0) begin
            col = col - 1;
          end
          if (col < cols_lim && row < rows_lim) begin
            draw_cell(CHR_SPACE, col, row);
          end
        end
        CHR_LF: begin
          col = 0;
          row = sat_cursor(row + 1);
        end
        CHR_TAB: begin
          col = sat_cursor((col + TAB_STOP) / TAB_STOP * TAB_STOP);
        end
        default: begin
          if (col >= cols_lim) begin
            col = 0;
            row = sat_cursor(row + 1);
          end
          if (row >= rows_lim) begin
            item_rows.push_back(SCROLL_BEAT);
            row = rows_lim - 1;
          end
          draw_cell(it.char_code, col, row);
          col = sat_cursor(col + 1);
        end
      endcase
      cur_col = CURSOR_W'(col);
      cur_row = CURSOR_W'(row);
    end
  endfunction

  // Offers one transaction after an optional gap and holds it until the
  // block takes it. Valid is only lowered when a gap actually follows, so a
  // back-to-back stream keeps it high with no glitch in between.
  task automatic send_item(input in_t it);
    int gap;
    gap = src_steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    interpret_console_item(it);
    foreach (item_rows[i]) begin
      due_rows.push_back(item_rows[i]);
    end
    items_sent++;
    if (it.opcode == OP_FONT_LOAD) begin
      loads_sent++;
    end
  endtask

  // Loads whatever rows of a glyph are still missing, with random bits.
  task automatic ensure_glyph(input logic [7:0] code);
    int unsigned base;
    base = code * GLYPH_HEIGHT;
    for (int y = 0; y < GLYPH_HEIGHT; y++) begin
      if (!glyph_ok[base + y]) begin
        send_item(font_load(12'(base + y), 8'($urandom)));
      end
    end
    if (!pooled[code]) begin
      pooled[code] = 1'b1;
      glyph_pool.push_back(code);
    end
  endtask

  // Sends a transaction after making sure any glyph it may draw is loaded.
  // A backspace draws the space glyph, so that one is loaded for it.
  task automatic issue(input in_t it);
    if (it.opcode == OP_CHAR) begin
      case (it.char_code)
        CHR_NUL, CHR_TAB, CHR_LF: ;
        CHR_BS:  ensure_glyph(CHR_SPACE);
        default: ensure_glyph(it.char_code);
      endcase
    end
    send_item(it);
  endtask

  // Stops offering input and waits for every owed result, then a little
  // longer so that a transaction with no result has surely finished.
  task automatic drain(input int bound);
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (due_rows.size() != 0 && waited < bound) begin
      @(posedge clk);
      waited++;
    end
    if (due_rows.size() != 0) begin
      tally_error($sformatf("%0d results never arrived, oldest expected %s",
                            due_rows.size(), show(due_rows[0])));
      due_rows.delete();
    end
    repeat (GLYPH_HEIGHT + 8) @(posedge clk);
  endtask

  // Writes both screen registers, columns first and then rows. The block must be
  // idle, which every caller ensures through drain.
  task automatic set_screen(input logic [REG_W-1:0] c, input logic [REG_W-1:0] r);
    cfg_we    <= 1'b1;
    cfg_index <= REG_COLUMNS;
    cfg_data  <= c;
    @(posedge clk);
    cfg_index <= REG_ROWS;
    cfg_data  <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    scr_cols = c;
    scr_rows = r;
    screens_set++;
  endtask

  task automatic plan_item(input in_t it, input int count, input out_t head);
    plan_steps.push_back('{1'b0, '0, '0, it, count, head});
  endtask

  task automatic plan_screen(input logic [REG_W-1:0] c, input logic [REG_W-1:0] r);
    plan_steps.push_back('{1'b1, c, r, '0, 0, '0});
  endtask

  // One random phase at a given screen size. Printable bytes dominate so the
  // cursor walks across the screen, wraps and scrolls; control bytes, font
  // rewrites and short bursts of tabs and newlines are mixed in.
  task automatic random_phase(input logic [REG_W-1:0] c, input logic [REG_W-1:0] r,
                              input int count, input bit pause);
    int pick;
    drain(DRAIN_BOUND);
    set_screen(c, r);
    src_steady = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < count; k++) begin
      // Once in the run the sender goes quiet until everything has drained.
      if (pause && k == count / 2) begin
        drain(DRAIN_BOUND);
      end
      if (k % 6 == 5) begin
        src_steady = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        issue(console_byte(pick_printable()));
      end else if (pick < 60) begin
        issue(console_byte(CHR_BS));
      end else if (pick < 70) begin
        issue(console_byte(CHR_LF));
      end else if (pick < 78) begin
        issue(console_byte(CHR_TAB));
      end else if (pick < 82) begin
        issue(console_byte(CHR_NUL));
      end else if (pick < 94) begin
        // Full 12-bit address range, so a quarter of these fall off the store.
        issue(font_load(12'($urandom), 8'($urandom)));
      end else begin
        repeat ($urandom_range(2, 6)) begin
          issue(console_byte($urandom_range(0, 1) ? CHR_TAB : CHR_LF));
        end
      end
    end
  endtask

  // Output checker: every accepted result must match the oldest one owed.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      outputs_seen++;
      if (out_data.kind == KIND_SCROLL) begin
        scrolls_seen++;
      end
      if (due_rows.size() == 0) begin
        tally_error($sformatf("unexpected result: %s", show(out_data)));
      end else begin
        oldest = due_rows.pop_front();
        if (out_data.kind !== oldest.kind || out_data.pixel_x !== oldest.pixel_x ||
            out_data.pixel_y !== oldest.pixel_y || out_data.pattern !== oldest.pattern ||
            out_data.last !== oldest.last) begin
          tally_error($sformatf("result mismatch: expected %s, actual %s",
                                show(oldest), show(out_data)));
        end
      end
    end
  end

  // Receiver: random stalls with stretches of steady acceptance, plus one
  // long hold-off while the sender keeps offering input, so the block backs
  // up into its input channel.
  initial begin : sink
    int  stall_left;
    int  tick;
    bit  sink_steady;
    bit  held_off;
    out_ready <= 1'b0;
    stall_left = 0;
    tick = 0;
    sink_steady = 1'b0;
    held_off = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (tick % 128 == 0) begin
        sink_steady = ($urandom_range(0, 3) == 0);
      end
      if (!held_off && outputs_seen >= HOLD_AFTER) begin
        held_off = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!sink_steady) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // Sender and sequencing of the whole run.
  initial begin : stimulus
    plan_step_t s;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_COLUMNS;
    cfg_data  <= '0;
    scr_cols = COLUMNS_RESET;
    scr_rows = ROWS_RESET;
    cur_col = '0;
    cur_row = '0;
    src_steady = 1'b0;

    // Directed plan, at the reset screen size of 80 by 40 first. Loads past
    // the end of the store and the first and last store entries, NUL, a
    // backspace at column 0, tab and newline, and the extreme codes.
    plan_item(font_load(12'd4095, 8'hA5), 0, '0);
    plan_item(font_load(12'd3072, 8'h5A), 0, '0);
    plan_item(font_load(12'd0, 8'hFF), 0, '0);
    plan_item(font_load(12'd3071, 8'h81), 0, '0);
    plan_item(console_byte(CHR_NUL), 0, '0);
    plan_item(console_byte(CHR_BS), PREDICTED, '0);
    plan_item(console_byte(8'h41), PREDICTED, '0);
    plan_item(console_byte(CHR_TAB), 0, '0);
    plan_item(console_byte(8'hFF), PREDICTED, '0);
    plan_item(console_byte(CHR_LF), 0, '0);
    plan_item(console_byte(8'h01), PREDICTED, '0);
    plan_item(console_byte(CHR_BS), PREDICTED, '0);
    plan_item(console_byte(8'h41), PREDICTED, '0);
    // Both registers written as zero, which the block treats as a single
    // cell screen: the cursor sits below it, so every character scrolls
    // first, and a tab followed by a backspace lands off screen.
    plan_screen(9'd0, 9'd0);
    plan_item(console_byte(CHR_LF), 0, '0);
    plan_item(console_byte(8'h01), GLYPH_HEIGHT + 1, SCROLL_BEAT);
    plan_item(console_byte(8'hFF), GLYPH_HEIGHT + 1, SCROLL_BEAT);
    plan_item(console_byte(CHR_BS), PREDICTED, '0);
    plan_item(console_byte(CHR_TAB), 0, '0);
    plan_item(console_byte(CHR_BS), 0, '0);
    plan_item(console_byte(8'h41), GLYPH_HEIGHT + 1, SCROLL_BEAT);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan_steps[i]) begin
      s = plan_steps[i];
      if (s.screen) begin
        drain(DRAIN_BOUND);
        set_screen(s.cols, s.nrows);
      end else begin
        issue(s.item);
        // Hand-written rows must agree with what the predictor produced.
        if (s.count != PREDICTED) begin
          if (item_rows.size() != s.count) begin
            tally_error($sformatf("plan row %0d: expected %0d results, actual %0d",
                                  i, s.count, item_rows.size()));
          end else if (s.count > 0 && item_rows[0] !== s.head) begin
            tally_error($sformatf("plan row %0d: expected head %s, actual %s",
                                  i, show(s.head), show(item_rows[0])));
          end
        end
      end
    end

    // Random phases: the clamped minimum, a small screen with a mid-phase
    // pause, the clamped maximum, the true maximum, a random size, and back
    // to the reset size.
    random_phase(9'd0, 9'd0, 6, 1'b0);
    random_phase(9'($urandom_range(2, 24)), 9'($urandom_range(1, 6)), 6, 1'b1);
    random_phase(9'd511, 9'd511, 6, 1'b0);
    random_phase(9'd256, 9'd256, 6, 1'b0);
    random_phase(9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)), 6, 1'b0);
    random_phase(9'(COLUMNS_RESET), 9'(ROWS_RESET), 8, 1'b0);

    drain(DRAIN_BOUND);

    $display("summary: %0d input transactions (%0d font loads) over %0d screen sizes",
             items_sent, loads_sent, screens_set);
    $display("summary: %0d output transactions checked, %0d of them scrolls",
             outputs_seen, scrolls_seen);
    if (errors == 0) begin
      $display("tb_text_console_glyph_renderer_top: clean");
    end else begin
      $display("tb_text_console_glyph_renderer_top: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #2000000;
    $display("tb_text_console_glyph_renderer_top: errors");
    $finish;
  end

endmodule
